/* rtl/core/bblur_pkg.sv */
// ----------------------------------------------------------------------------
// bblur_pkg
// Shared constants, command/status bundles and divide tables for the
// edge-aware 3x3 box blur core.
// ----------------------------------------------------------------------------
package bblur_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int WID_W      = $clog2(MAX_WIDTH + 1);
  localparam int PEND_W     = $clog2(MAX_WIDTH + 2);
  localparam int ROW_W      = 16;
  localparam int FW_W       = 11;
  localparam int FH_W       = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam int PIX_W      = 8;
  localparam int RGB_W      = 3 * PIX_W;
  localparam int SUM_W      = 12;
  localparam int NUM_W      = SUM_W + 1;
  localparam int CNT_W      = 4;
  localparam int RCP_W      = 20;
  localparam int RCP_SH     = 20;
  localparam int PROD_W     = NUM_W + RCP_W;
  localparam int SLOT_W     = 2;
  localparam int ADDR_W     = SLOT_W + COL_W;
  localparam int MEM_DEPTH  = 3 << COL_W;

  localparam logic [FW_W-1:0] FW_RESET = FW_W'(1024);
  localparam logic [FH_W-1:0] FH_RESET = FH_W'(1);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  // input item kinds
  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  // neighbour offsets within a 3x3 window
  localparam logic [1:0] TAP_LO  = 2'd0;
  localparam logic [1:0] TAP_MID = 2'd1;
  localparam logic [1:0] TAP_HI  = 2'd2;

  typedef struct packed {
    logic       load_in;
    logic       rd;
    logic [1:0] tap_row;
    logic [1:0] tap_col;
    logic       div;
    logic       emit;
    logic       wr_pix;
  } bb_cmd_t;

  typedef struct packed {
    logic is_drain;
    logic in_done;
    logic ready;
    logic out_free;
  } bb_stat_t;

  function automatic logic [CNT_W-1:0] cnt_of(input logic [1:0] rn, input logic [1:0] cn);
    return CNT_W'(rn) * CNT_W'(cn);
  endfunction

  // ceil(2^RCP_SH / (2*cnt)), exact for numerators below 2^NUM_W
  function automatic logic [RCP_W-1:0] recip_of(input logic [CNT_W-1:0] cnt);
    logic [RCP_W-1:0] m;
    unique case (cnt)
      4'd1:    m = RCP_W'(524288);
      4'd2:    m = RCP_W'(262144);
      4'd3:    m = RCP_W'(174763);
      4'd4:    m = RCP_W'(131072);
      4'd6:    m = RCP_W'(87382);
      4'd9:    m = RCP_W'(58255);
      default: m = '0;
    endcase
    return m;
  endfunction

endpackage

/* rtl/core/box_blur_3x3_edge_aware_core.sv */
// a taken beat is loaded and checked; a pixel that completes no window is stored in history,
// a beat that completes a window reads its nine taps, divides and emits the result, then
// stores its pixel (a drain tick stores nothing); other beats are ignored; in_stall holds
// off the next beat until this work is done, and the nine taps are read one by one through the single history
// memory port; a result beat waits while the previous result is held by out_stall
// reset clears position counters and loads width 1024, height 1; history is not cleared
// ----------------------------------------------------------------------------
// box_blur_3x3_edge_aware_core
// Edge-aware 3x3 box blur on a raster RGB stream, output lagging by width+1.
// ----------------------------------------------------------------------------
module box_blur_3x3_edge_aware_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [bblur_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bblur_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_cmd,
  input  logic [bblur_pkg::PIX_W-1:0]      in_red,
  input  logic [bblur_pkg::PIX_W-1:0]      in_green,
  input  logic [bblur_pkg::PIX_W-1:0]      in_blue,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [bblur_pkg::PIX_W-1:0]      out_red,
  output logic [bblur_pkg::PIX_W-1:0]      out_green,
  output logic [bblur_pkg::PIX_W-1:0]      out_blue,
  output logic                             out_frame_end
);
  import bblur_pkg::*;

  bb_cmd_t  cmd;
  bb_stat_t stat;

  bblur_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  bblur_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_cmd        (in_cmd),
    .in_red        (in_red),
    .in_green      (in_green),
    .in_blue       (in_blue),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_red       (out_red),
    .out_green     (out_green),
    .out_blue      (out_blue),
    .out_frame_end (out_frame_end),
    .cmd           (cmd),
    .stat          (stat)
  );

endmodule

/* rtl/core/bblur_ctrl.sv */
// ----------------------------------------------------------------------------
// bblur_ctrl
// Sequencer: decides per beat whether to store, blur or skip, and walks the
// nine window taps through the history memory.
// ----------------------------------------------------------------------------
module bblur_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  bblur_pkg::bb_stat_t stat,
  output bblur_pkg::bb_cmd_t  cmd
);
  import bblur_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_READ,
    ST_SETTLE,
    ST_DIV,
    ST_EMIT,
    ST_WRITE
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] tap_row_r, tap_row_nxt;
  logic [1:0] tap_col_r, tap_col_nxt;

  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    state_nxt   = state_r;
    tap_row_nxt = tap_row_r;
    tap_col_nxt = tap_col_r;
    cmd         = '0;
    cmd.tap_row = tap_row_r;
    cmd.tap_col = tap_col_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = ST_CHECK;
        end
      end
      ST_CHECK: begin
        tap_row_nxt = TAP_LO;
        tap_col_nxt = TAP_LO;
        priority if (stat.is_drain) begin
          state_nxt = stat.in_done ? ST_READ : ST_IDLE;
        end else if (stat.in_done) begin
          state_nxt = ST_IDLE;
        end else if (stat.ready) begin
          state_nxt = ST_READ;
        end else begin
          state_nxt = ST_WRITE;
        end
      end
      ST_READ: begin
        cmd.rd = 1'b1;
        if (tap_col_r == TAP_HI) begin
          tap_col_nxt = TAP_LO;
          if (tap_row_r == TAP_HI) begin
            state_nxt = ST_SETTLE;
          end else begin
            tap_row_nxt = tap_row_r + 2'd1;
          end
        end else begin
          tap_col_nxt = tap_col_r + 2'd1;
        end
      end
      ST_SETTLE: begin
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.div   = 1'b1;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = stat.is_drain ? ST_IDLE : ST_WRITE;
        end
      end
      ST_WRITE: begin
        cmd.wr_pix = 1'b1;
        state_nxt  = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      tap_row_r <= TAP_LO;
      tap_col_r <= TAP_LO;
    end else begin
      state_r   <= state_nxt;
      tap_row_r <= tap_row_nxt;
      tap_col_r <= tap_col_nxt;
    end
  end

endmodule

/* rtl/core/bblur_dp.sv */
// ----------------------------------------------------------------------------
// bblur_dp
// Datapath: frame registers, position counters, three-row history memory,
// window accumulators, reciprocal divide and the output register.
// ----------------------------------------------------------------------------
module bblur_dp (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [bblur_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [bblur_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic                                   in_cmd,
  input  logic [bblur_pkg::PIX_W-1:0]            in_red,
  input  logic [bblur_pkg::PIX_W-1:0]            in_green,
  input  logic [bblur_pkg::PIX_W-1:0]            in_blue,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [bblur_pkg::PIX_W-1:0]            out_red,
  output logic [bblur_pkg::PIX_W-1:0]            out_green,
  output logic [bblur_pkg::PIX_W-1:0]            out_blue,
  output logic                                   out_frame_end,
  input  bblur_pkg::bb_cmd_t                     cmd,
  output bblur_pkg::bb_stat_t                    stat
);
  import bblur_pkg::*;

  function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
    return (s == SLOT_W'(2)) ? SLOT_W'(0) : SLOT_W'(s + SLOT_W'(1));
  endfunction

  function automatic logic [SLOT_W-1:0] slot_dec(input logic [SLOT_W-1:0] s);
    return (s == SLOT_W'(0)) ? SLOT_W'(2) : SLOT_W'(s - SLOT_W'(1));
  endfunction

  // configuration and position state
  logic [FW_W-1:0]   frame_width_r;
  logic [FH_W-1:0]   frame_height_r;
  logic [ROW_W-1:0]  in_row_r, out_row_r;
  logic [COL_W-1:0]  in_col_r, out_col_r;
  logic [SLOT_W-1:0] in_slot_r, out_slot_r;
  logic [PEND_W-1:0] pend_r;
  logic              out_valid_r;
  logic              tap_vld_d_r;

  // payload
  logic              is_drain_r;
  logic [RGB_W-1:0]  in_pix_r;
  logic [RGB_W-1:0]  mem [0:MEM_DEPTH-1];
  logic [RGB_W-1:0]  mem_q_r;
  logic              tap_inc_r;
  logic              tap_cur_r;
  logic [SUM_W-1:0]  acc_r_r, acc_g_r, acc_b_r;
  logic [PROD_W-1:0] prod_r_r, prod_g_r, prod_b_r;
  logic [PIX_W-1:0]  out_red_r, out_green_r, out_blue_r;
  logic              out_frame_end_r;

  logic [WID_W-1:0]  w_eff;
  logic [FH_W-1:0]   h_eff;
  logic              cfg_wr;
  logic              row_lo_ok, row_hi_ok, col_lo_ok, col_hi_ok;
  logic              out_last, out_row_end, in_row_end;
  logic              tap_row_ok, tap_col_ok;
  logic [SLOT_W-1:0] rd_slot;
  logic [COL_W-1:0]  rd_col;
  logic [RGB_W-1:0]  acc_pix;
  logic [1:0]        rows_n, cols_n;
  logic [CNT_W-1:0]  cnt;
  logic [RCP_W-1:0]  rcp;
  logic [NUM_W-1:0]  num_r, num_g, num_b;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid;

  always_comb begin
    priority if (frame_width_r == '0) begin
      w_eff = WID_W'(1);
    end else if (32'(frame_width_r) > 32'(MAX_WIDTH)) begin
      w_eff = WID_W'(MAX_WIDTH);
    end else begin
      w_eff = WID_W'(frame_width_r);
    end
  end

  assign h_eff = (frame_height_r == '0) ? FH_W'(1) : frame_height_r;

  // window edges of the output pixel
  assign row_lo_ok   = (out_row_r != '0);
  assign row_hi_ok   = (32'(out_row_r) + 32'd1) < 32'(h_eff);
  assign col_lo_ok   = (out_col_r != '0);
  assign col_hi_ok   = (32'(out_col_r) + 32'd1) < 32'(w_eff);
  assign out_row_end = !col_hi_ok;
  assign out_last    = !row_hi_ok && out_row_end;
  assign in_row_end  = (32'(in_col_r) + 32'd1) >= 32'(w_eff);

  assign stat.is_drain = is_drain_r;
  assign stat.in_done  = 32'(in_row_r) >= 32'(h_eff);
  assign stat.ready    = 32'(pend_r) >= (32'(w_eff) + 32'd1);
  assign stat.out_free = !out_valid_r || !out_stall;

  always_comb begin
    unique case (cmd.tap_row)
      TAP_LO:  begin tap_row_ok = row_lo_ok; rd_slot = slot_dec(out_slot_r); end
      TAP_MID: begin tap_row_ok = 1'b1;      rd_slot = out_slot_r;           end
      TAP_HI:  begin tap_row_ok = row_hi_ok; rd_slot = slot_inc(out_slot_r); end
      default: begin tap_row_ok = 1'b0;      rd_slot = out_slot_r;           end
    endcase
    unique case (cmd.tap_col)
      TAP_LO:  tap_col_ok = col_lo_ok;
      TAP_MID: tap_col_ok = 1'b1;
      TAP_HI:  tap_col_ok = col_hi_ok;
      default: tap_col_ok = 1'b0;
    endcase
  end

  // column wraps harmlessly when the tap is outside the frame
  assign rd_col  = COL_W'(out_col_r + COL_W'(cmd.tap_col) - COL_W'(1));
  assign acc_pix = tap_cur_r ? in_pix_r : mem_q_r;

  assign rows_n = 2'd1 + 2'(row_lo_ok) + 2'(row_hi_ok);
  assign cols_n = 2'd1 + 2'(col_lo_ok) + 2'(col_hi_ok);
  assign cnt    = cnt_of(rows_n, cols_n);
  assign rcp    = recip_of(cnt);
  assign num_r  = {acc_r_r, 1'b0} + NUM_W'(cnt);
  assign num_g  = {acc_g_r, 1'b0} + NUM_W'(cnt);
  assign num_b  = {acc_b_r, 1'b0} + NUM_W'(cnt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= FW_RESET;
      frame_height_r <= FH_RESET;
      in_row_r       <= '0;
      in_col_r       <= '0;
      in_slot_r      <= '0;
      out_row_r      <= '0;
      out_col_r      <= '0;
      out_slot_r     <= '0;
      pend_r         <= '0;
      out_valid_r    <= 1'b0;
      tap_vld_d_r    <= 1'b0;
    end else begin
      tap_vld_d_r <= cmd.rd;
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_wr) begin
        unique case (cfg_index)
          REG_FRAME_WIDTH:  frame_width_r  <= cfg_data[FW_W-1:0];
          REG_FRAME_HEIGHT: frame_height_r <= cfg_data[FH_W-1:0];
        endcase
        in_row_r   <= '0;
        in_col_r   <= '0;
        in_slot_r  <= '0;
        out_row_r  <= '0;
        out_col_r  <= '0;
        out_slot_r <= '0;
        pend_r     <= '0;
      end else if (cmd.emit) begin
        if (out_last) begin
          in_row_r   <= '0;
          in_col_r   <= '0;
          in_slot_r  <= '0;
          out_row_r  <= '0;
          out_col_r  <= '0;
          out_slot_r <= '0;
          pend_r     <= '0;
        end else begin
          pend_r <= pend_r - PEND_W'(1);
          if (out_row_end) begin
            out_col_r  <= '0;
            out_row_r  <= out_row_r + ROW_W'(1);
            out_slot_r <= slot_inc(out_slot_r);
          end else begin
            out_col_r <= out_col_r + COL_W'(1);
          end
        end
      end else if (cmd.wr_pix) begin
        pend_r <= pend_r + PEND_W'(1);
        if (in_row_end) begin
          in_col_r  <= '0;
          in_row_r  <= in_row_r + ROW_W'(1);
          in_slot_r <= slot_inc(in_slot_r);
        end else begin
          in_col_r <= in_col_r + COL_W'(1);
        end
      end
    end
  end

  // history memory: reads of the window come first, the new pixel is stored last
  always_ff @(posedge clk) begin
    if (cmd.wr_pix) begin
      mem[{in_slot_r, in_col_r}] <= in_pix_r;
    end
    if (cmd.rd) begin
      mem_q_r <= mem[{rd_slot, rd_col}];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      is_drain_r <= (in_cmd == CMD_DRAIN);
      in_pix_r   <= {in_red, in_green, in_blue};
    end
    if (cmd.rd) begin
      tap_inc_r <= tap_row_ok && tap_col_ok;
      // bottom-right tap is the pixel arriving now, not yet in memory
      tap_cur_r <= (cmd.tap_row == TAP_HI) && (cmd.tap_col == TAP_HI) && !is_drain_r;
    end
    if (cmd.load_in) begin
      acc_r_r <= '0;
      acc_g_r <= '0;
      acc_b_r <= '0;
    end else if (tap_vld_d_r && tap_inc_r) begin
      acc_r_r <= acc_r_r + SUM_W'(acc_pix[2*PIX_W +: PIX_W]);
      acc_g_r <= acc_g_r + SUM_W'(acc_pix[PIX_W +: PIX_W]);
      acc_b_r <= acc_b_r + SUM_W'(acc_pix[0 +: PIX_W]);
    end
    if (cmd.div) begin
      prod_r_r <= PROD_W'(num_r) * PROD_W'(rcp);
      prod_g_r <= PROD_W'(num_g) * PROD_W'(rcp);
      prod_b_r <= PROD_W'(num_b) * PROD_W'(rcp);
    end
    if (cmd.emit) begin
      out_red_r       <= prod_r_r[RCP_SH +: PIX_W];
      out_green_r     <= prod_g_r[RCP_SH +: PIX_W];
      out_blue_r      <= prod_b_r[RCP_SH +: PIX_W];
      out_frame_end_r <= out_last;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_red       = out_red_r;
  assign out_green     = out_green_r;
  assign out_blue      = out_blue_r;
  assign out_frame_end = out_frame_end_r;

endmodule

/* rtl/core/bblur_chk.sv */
// ----------------------------------------------------------------------------
// bblur_chk
// Port-level checks for the box blur core, bound to the top level.
// ----------------------------------------------------------------------------
module bblur_chk (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_stall,
  input logic                             out_valid,
  input logic                             out_stall,
  input logic [bblur_pkg::PIX_W-1:0]      out_red,
  input logic [bblur_pkg::PIX_W-1:0]      out_green,
  input logic [bblur_pkg::PIX_W-1:0]      out_blue,
  input logic                             out_frame_end
);

  // no result is left over from before reset
  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // a taken beat always makes the sequencer busy in the next cycle
  a_busy_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after a beat was taken");

  // a new result only comes out of work on a taken beat
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared while the core was idle");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_red) && $stable(out_green) &&
      $stable(out_blue) && $stable(out_frame_end))
    else $error("stalled result changed");

endmodule

bind box_blur_3x3_edge_aware_core bblur_chk u_bblur_chk (.*);

/* test/box_blur_3x3_edge_aware_core_test.sv */
// ----------------------------------------------------------------------------
// box_blur_3x3_edge_aware_core_test
// Self-checking bench for the edge-aware 3x3 box blur core. A short directed
// table walks the corner cases, then random frames of mostly small size are
// streamed with random gaps on both sides and checked beat by beat against
// an in-bench blur predictor.
// ----------------------------------------------------------------------------
module box_blur_3x3_edge_aware_core_test;
  import bblur_pkg::*;

  localparam int HIST_DEPTH     = 2 * MAX_WIDTH + 2;
  localparam int ITEM_TARGET    = 1700;
  localparam int SETTLE_CYCLES  = 32;
  localparam int RX_HOLD_CYCLES = 400;
  localparam int CYCLE_LIMIT    = 600000;
  localparam int DIR_ROWS       = 32;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
  } rgb_t;

  typedef struct packed {
    rgb_t pix;
    logic frame_end;
  } blur_px_t;

  typedef enum logic [1:0] {OP_PIXEL, OP_DRAIN, OP_SET_WIDTH, OP_SET_HEIGHT} dir_op_t;
  // CHK_MODEL: predictor decides; CHK_NONE / CHK_VALUE: expectation typed in the table
  typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_VALUE} chk_t;

  typedef struct packed {
    dir_op_t          op;
    logic [15:0]      arg;
    rgb_t             px;
    chk_t             chk;
    blur_px_t         want;
  } dir_row_t;

  localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
    // reset setup: a drain before the frame is in does nothing
    '{OP_DRAIN,      16'h0000, 24'h000000, CHK_NONE,  25'h0},
    // width zero and height zero act as a single pixel frame
    '{OP_SET_WIDTH,  16'h0000, 24'h000000, CHK_MODEL, 25'h0},
    '{OP_SET_HEIGHT, 16'h0000, 24'h000000, CHK_MODEL, 25'h0},
    '{OP_DRAIN,      16'h0000, 24'h000000, CHK_NONE,  25'h0},
    '{OP_PIXEL,      16'h0000, 24'hFF00FF, CHK_NONE,  25'h0},
    '{OP_PIXEL,      16'h0000, 24'h123456, CHK_NONE,  25'h0},
    '{OP_DRAIN,      16'h0000, 24'h000000, CHK_VALUE, {24'hFF00FF, 1'b1}},
    '{OP_DRAIN,      16'h0000, 24'h000000, CHK_NONE,  25'h0},
    '{OP_PIXEL,      16'h0000, 24'h00FF00, CHK_NONE,  25'h0},
    '{OP_DRAIN,      16'h0000, 24'h000000, CHK_VALUE, {24'h00FF00, 1'b1}},
    // upper data bits of the width write are dropped: 3x1, divisors 2 and 3
    '{OP_SET_WIDTH,  16'hF803, 24'h000000, CHK_MODEL, 25'h0},
    '{OP_SET_HEIGHT, 16'h0001, 24'h000000, CHK_MODEL, 25'h0},
    '{OP_PIXEL,      16'h0000, 24'h000000, CHK_MODEL, 25'h0},
    '{OP_PIXEL,      16'h0000, 24'h0101FF, CHK_MODEL, 25'h0},
    '{OP_PIXEL,      16'h0000, 24'h00FF00, CHK_MODEL, 25'h0},
    '{OP_DRAIN,      16'h0000, 24'h000000, CHK_MODEL, 25'h0},
    '{OP_DRAIN,      16'h0000, 24'h000000, CHK_MODEL, 25'h0},
    '{OP_DRAIN,      16'h0000, 24'h000000, CHK_MODEL, 25'h0},
    // 3x3: divisors 4, 6 and 9
    '{OP_SET_HEIGHT, 16'h0003, 24'h000000, CHK_MODEL, 25'h0},
    '{OP_PIXEL,      16'h0000, 24'hFFFFFF, CHK_MODEL, 25'h0},
    '{OP_PIXEL,      16'h0000, 24'h000000, CHK_MODEL, 25'h0},
    '{OP_PIXEL,      16'h0000, 24'hFFFFFF, CHK_MODEL, 25'h0},
    '{OP_PIXEL,      16'h0000, 24'h000000, CHK_MODEL, 25'h0},
    '{OP_PIXEL,      16'h0000, 24'h808080, CHK_MODEL, 25'h0},
    '{OP_PIXEL,      16'h0000, 24'h7F7F7F, CHK_MODEL, 25'h0},
    '{OP_PIXEL,      16'h0000, 24'h010203, CHK_MODEL, 25'h0},
    '{OP_PIXEL,      16'h0000, 24'hFEFDFC, CHK_MODEL, 25'h0},
    '{OP_PIXEL,      16'h0000, 24'hFFFFFF, CHK_MODEL, 25'h0},
    '{OP_DRAIN,      16'h0000, 24'h000000, CHK_MODEL, 25'h0},
    '{OP_DRAIN,      16'h0000, 24'h000000, CHK_MODEL, 25'h0},
    '{OP_DRAIN,      16'h0000, 24'h000000, CHK_MODEL, 25'h0},
    '{OP_DRAIN,      16'h0000, 24'h000000, CHK_MODEL, 25'h0}
  };

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  in_cmd = CMD_PIXEL;
  logic [PIX_W-1:0]      in_red = '0;
  logic [PIX_W-1:0]      in_green = '0;
  logic [PIX_W-1:0]      in_blue = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [PIX_W-1:0]      out_red;
  logic [PIX_W-1:0]      out_green;
  logic [PIX_W-1:0]      out_blue;
  logic                  out_frame_end;

  // typed expectation travels with the beat like payload
  chk_t                  typed_chk = CHK_MODEL;
  blur_px_t              typed_want = '0;

  box_blur_3x3_edge_aware_core dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_cmd        (in_cmd),
    .in_red        (in_red),
    .in_green      (in_green),
    .in_blue       (in_blue),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_red       (out_red),
    .out_green     (out_green),
    .out_blue      (out_blue),
    .out_frame_end (out_frame_end)
  );

  // blur predictor state
  rgb_t             hist [HIST_DEPTH];
  int unsigned      in_row, in_col, out_row, out_col;
  logic [FW_W-1:0]  fw_reg;
  logic [FH_W-1:0]  fh_reg;

  blur_px_t         blur_due [$];
  int               mismatches = 0;
  int               items_used = 0;
  int               cycle_count = 0;
  int               rx_hold_reqs = 0;
  int               rx_holds_done = 0;
  bit               tx_steady = 1'b0;

  function automatic int unsigned eff_w();
    if (fw_reg == 0) return 1;
    if (fw_reg > MAX_WIDTH) return MAX_WIDTH;
    return fw_reg;
  endfunction

  function automatic int unsigned eff_h();
    return (fh_reg == 0) ? 1 : fh_reg;
  endfunction

  function automatic void clear_pos();
    in_row = 0;
    in_col = 0;
    out_row = 0;
    out_col = 0;
  endfunction

  // mean of the in-frame neighbours of the next output pixel, then advance it
  function automatic blur_px_t blur_window(input bit has_cur, input int unsigned cur,
                                           input rgb_t px);
    int unsigned w, h, rr, cc, lin, cnt, sr, sg, sb;
    int dr, dc;
    rgb_t p;
    blur_px_t res;
    w = eff_w();
    h = eff_h();
    cnt = 0;
    sr = 0;
    sg = 0;
    sb = 0;
    for (dr = -1; dr <= 1; dr++) begin
      for (dc = -1; dc <= 1; dc++) begin
        if ((dr < 0 && out_row == 0) || (dc < 0 && out_col == 0)) continue;
        rr = int'(out_row) + dr;
        cc = int'(out_col) + dc;
        if (rr >= h || cc >= w) continue;
        lin = rr * w + cc;
        p = (has_cur && lin == cur) ? px : hist[lin % HIST_DEPTH];
        sr += p.red;
        sg += p.green;
        sb += p.blue;
        cnt++;
      end
    end
    if (cnt == 0) cnt = 1;
    res.pix.red   = PIX_W'((2 * sr + cnt) / (2 * cnt));
    res.pix.green = PIX_W'((2 * sg + cnt) / (2 * cnt));
    res.pix.blue  = PIX_W'((2 * sb + cnt) / (2 * cnt));
    res.frame_end = (out_row + 1 >= h) && (out_col + 1 >= w);
    if (res.frame_end) begin
      clear_pos();
    end else if (out_col + 1 >= w) begin
      out_col = 0;
      out_row++;
    end else begin
      out_col++;
    end
    return res;
  endfunction

  // one accepted beat; returns 1 when it releases an output pixel
  function automatic bit blur_step(input logic cmd, input rgb_t px, output blur_px_t res);
    int unsigned w, h, cur, out_lin;
    bit in_done, rdy;
    w = eff_w();
    h = eff_h();
    in_done = in_row >= h;
    out_lin = out_row * w + out_col;
    res = '0;
    if (cmd == CMD_PIXEL) begin
      if (in_done) return 1'b0;
      items_used++;
      cur = in_row * w + in_col;
      rdy = (cur + 1) >= out_lin + w + 2;
      if (rdy) res = blur_window(1'b1, cur, px);
      hist[cur % HIST_DEPTH] = px;
      if (rdy && res.frame_end) return 1'b1;
      if (in_col + 1 >= w) begin
        in_col = 0;
        in_row++;
      end else begin
        in_col++;
      end
      return rdy;
    end
    if (!in_done) return 1'b0;
    items_used++;
    res = blur_window(1'b0, 0, '0);
    return 1'b1;
  endfunction

  // sender gap: mostly none, some short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic rgb_t rand_px();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return rgb_t'($urandom);
  endfunction

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Mismatches found");
    $finish;
  end

  // receiver pacing, with a long hold-off on request
  initial begin : rx_pacing
    int r;
    @(posedge clk);
    forever begin
      r = $urandom_range(0, 99);
      if (rx_hold_reqs != rx_holds_done) begin
        rx_holds_done++;
        out_stall <= 1'b1;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
      end else if (r < 5) begin
        out_stall <= 1'b0;
        repeat ($urandom_range(100, 250)) @(posedge clk);
      end else if (r < 60) begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else if (r < 93) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end else if (r < 98) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(4, 12)) @(posedge clk);
      end else begin
        out_stall <= 1'b1;
        repeat ($urandom_range(20, 60)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin : watch
    blur_px_t got, want, pred;
    bit has;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_FRAME_WIDTH) begin
          fw_reg = cfg_data[FW_W-1:0];
          clear_pos();
        end else if (cfg_index == REG_FRAME_HEIGHT) begin
          fh_reg = cfg_data[FH_W-1:0];
          clear_pos();
        end
      end
      if (out_valid && !out_stall) begin
        got = {out_red, out_green, out_blue, out_frame_end};
        if (blur_due.size() == 0) begin
          $error("output beat with nothing expected: %h", got);
          mismatches++;
        end else begin
          want = blur_due.pop_front();
          if (got.pix.red !== want.pix.red) begin
            $error("out_red: expected %0d, got %0d", want.pix.red, got.pix.red);
            mismatches++;
          end
          if (got.pix.green !== want.pix.green) begin
            $error("out_green: expected %0d, got %0d", want.pix.green, got.pix.green);
            mismatches++;
          end
          if (got.pix.blue !== want.pix.blue) begin
            $error("out_blue: expected %0d, got %0d", want.pix.blue, got.pix.blue);
            mismatches++;
          end
          if (got.frame_end !== want.frame_end) begin
            $error("out_frame_end: expected %0d, got %0d", want.frame_end, got.frame_end);
            mismatches++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        has = blur_step(in_cmd, {in_red, in_green, in_blue}, pred);
        case (typed_chk)
          CHK_VALUE: blur_due.push_back(typed_want);
          CHK_NONE:  ;
          default:   if (has) blur_due.push_back(pred);
        endcase
      end
    end
  end

  task automatic send_item(input logic cmd, input rgb_t px, input chk_t chk,
                           input blur_px_t want);
    int gap;
    gap = tx_steady ? 0 : pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_cmd     <= cmd;
    in_red     <= px.red;
    in_green   <= px.green;
    in_blue    <= px.blue;
    typed_chk  <= chk;
    typed_want <= want;
    do @(posedge clk); while (in_stall);
  endtask

  // wait for all pending pixels, then let dropped beats finish in the core
  task automatic settle();
    in_valid <= 1'b0;
    while (blur_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_phase(input int num);
    int unsigned ew, eh, npix, nfeed, ndrain, frames, k;
    int w, h, roll;
    logic [4:0] hi;
    bit partial, squeeze;
    settle();
    tx_steady = ($urandom_range(0, 3) == 0);
    hi = 5'($urandom);
    squeeze = (num % 8 == 3);
    if (num == 0) begin
      // widest frame, width at or above the maximum, short or tallest height
      write_reg(REG_FRAME_WIDTH, {hi, 11'($urandom_range(1024, 2047))});
      if ($urandom_range(0, 1) == 0) write_reg(REG_FRAME_HEIGHT, 16'hFFFF);
      else write_reg(REG_FRAME_HEIGHT, 16'($urandom_range(2, 3)));
    end else if (squeeze) begin
      write_reg(REG_FRAME_WIDTH, {hi, 11'($urandom_range(2, 6))});
      write_reg(REG_FRAME_HEIGHT, 16'($urandom_range(3, 8)));
      rx_hold_reqs++;
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 8) w = 0;
      else if (roll < 75) w = $urandom_range(1, 6);
      else w = $urandom_range(7, 40);
      roll = $urandom_range(0, 99);
      if (roll < 8) h = 0;
      else if (roll < 85) h = $urandom_range(1, 5);
      else h = $urandom_range(6, 65535);
      // sometimes only one of the two registers changes
      roll = $urandom_range(0, 2);
      if (roll != 2) write_reg(REG_FRAME_WIDTH, {hi, 11'(w)});
      if (roll != 1) write_reg(REG_FRAME_HEIGHT, 16'(h));
    end
    ew = eff_w();
    eh = eff_h();
    npix = ew * eh;
    partial = (num == 0) || npix > 300 ||
              (!squeeze && npix > 1 && $urandom_range(0, 99) < 8);
    frames = partial ? 1 : $urandom_range(1, 3);
    repeat (frames) begin
      nfeed = npix;
      if (num == 0) nfeed = MAX_WIDTH + 2 + $urandom_range(0, 40);
      else if (partial) nfeed = $urandom_range(1, (npix > 300) ? 300 : npix - 1);
      for (k = 0; k < nfeed; k++) begin
        // stray drain while the frame is still coming in
        if ($urandom_range(0, 99) < 4) send_item(CMD_DRAIN, '0, CHK_MODEL, '0);
        send_item(CMD_PIXEL, rand_px(), CHK_MODEL, '0);
      end
      if (!partial) begin
        // stray pixels once the whole frame is in
        if ($urandom_range(0, 99) < 15) begin
          repeat ($urandom_range(1, 2)) send_item(CMD_PIXEL, rand_px(), CHK_MODEL, '0);
        end
        ndrain = (ew + 1 < npix) ? ew + 1 : npix;
        repeat (ndrain) send_item(CMD_DRAIN, '0, CHK_MODEL, '0);
        if ($urandom_range(0, 99) < 10) send_item(CMD_DRAIN, '0, CHK_MODEL, '0);
      end
    end
  endtask

  initial begin : main
    int num;
    fw_reg = FW_RESET;
    fh_reg = FH_RESET;
    clear_pos();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIR_TAB[i]) begin
      case (DIR_TAB[i].op)
        OP_SET_WIDTH: begin
          settle();
          write_reg(REG_FRAME_WIDTH, DIR_TAB[i].arg);
        end
        OP_SET_HEIGHT: begin
          settle();
          write_reg(REG_FRAME_HEIGHT, DIR_TAB[i].arg);
        end
        OP_PIXEL: send_item(CMD_PIXEL, DIR_TAB[i].px, DIR_TAB[i].chk, DIR_TAB[i].want);
        default:  send_item(CMD_DRAIN, '0, DIR_TAB[i].chk, DIR_TAB[i].want);
      endcase
    end

    // one wide phase first, then the bulk on small frames
    run_phase(0);
    num = 1;
    while (items_used < ITEM_TARGET) begin
      run_phase(num);
      num++;
    end
    settle();

    if (mismatches == 0 && blur_due.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
